FILE: design/kplc_pkg.sv
`default_nettype none
package kplc_pkg;

  localparam int unsigned PIN_LENGTH  = 4;
  localparam int unsigned CNT_W       = $clog2(PIN_LENGTH + 1);
  localparam int unsigned ELAPSED_W   = 17;
  localparam int unsigned BLINK_W     = 9;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [4:0]           NO_KEY      = 5'd16;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
  localparam logic [BLINK_W-1:0]   BLINK_LAST  = 9'd299;

  typedef enum logic [2:0] {
    MODE_SLEEP    = 3'd0,
    MODE_LOCKED   = 3'd1,
    MODE_ENTERING = 3'd2,
    MODE_UNLOCKED = 3'd3,
    MODE_LOCKOUT  = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_WOKE    = 3'd1,
    EV_GRANTED = 3'd2,
    EV_WRONG   = 3'd3,
    EV_LOCKOUT = 3'd4,
    EV_SLEPT   = 3'd5,
    EV_ABORTED = 3'd6
  } event_e;

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_WAKE = 2'd1,
    ACT_KEY  = 2'd2,
    ACT_NOP  = 2'd3
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MASTER_CODE  = 3'd0,
    REG_WRONG_LIMIT  = 3'd1,
    REG_IDLE_SLEEP   = 3'd2,
    REG_ENTRY_TMO    = 3'd3,
    REG_UNLOCK_HOLD  = 3'd4,
    REG_LOCKOUT_HOLD = 3'd5
  } cfg_reg_e;

  // pad codes: 0-9 digits, letters, star, hash
  localparam logic [3:0] CODE_LETTER = 4'd10;
  localparam logic [3:0] CODE_STAR   = 4'd11;
  localparam logic [3:0] CODE_HASH   = 4'd12;

  typedef struct packed {
    logic [1:0] action;
    logic [4:0] key_position;
  } in_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       red_led;
    logic       green_led;
    logic [2:0] digits_entered;
    logic [3:0] tries_left;
    logic       key_click;
    logic [2:0] event_res;
  } out_t;

  function automatic logic [3:0] pad_code(input logic [3:0] pos);
    logic [3:0] c;
    case (pos)
      4'd0:  c = 4'd1;
      4'd1:  c = 4'd2;
      4'd2:  c = 4'd3;
      4'd4:  c = 4'd4;
      4'd5:  c = 4'd5;
      4'd6:  c = 4'd6;
      4'd8:  c = 4'd7;
      4'd9:  c = 4'd8;
      4'd10: c = 4'd9;
      4'd12: c = CODE_STAR;
      4'd13: c = 4'd0;
      4'd14: c = CODE_HASH;
      default: c = CODE_LETTER;
    endcase
    return c;
  endfunction

  // digit idx sits in nibble PIN_LENGTH-1-idx; nibbles above the code read as zero
  function automatic logic [3:0] pin_digit(input logic [15:0] code,
                                           input logic [CNT_W-1:0] idx);
    int unsigned n;
    logic [15:0] sh;
    n  = PIN_LENGTH - 1 - int'(idx);
    sh = code >> (4 * (n % 4));
    if (n >= 4) begin
      return 4'd0;
    end
    return sh[3:0];
  endfunction

endpackage
`default_nettype wire

FILE: design/kplc_out_buf.sv
`default_nettype none
module kplc_out_buf (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire kplc_pkg::out_t push_data_i,
  output logic                space_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output kplc_pkg::out_t      out_data_o
);

  logic           out_valid_q, skid_valid_q;
  kplc_pkg::out_t out_q, skid_q;
  logic           pop;

  assign pop         = out_valid_q && out_ready_i;
  assign space_o     = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_q <= push_data_i;
      end else begin
        skid_q <= push_data_i;
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/keypad_pin_lock_controller.sv
`default_nettype none
// Keypad PIN lock controller. Each input beat is a millisecond tick, a wake
// event, a keypad sample or a no-op, and yields exactly one result beat with
// the mode, LED drives, entry progress, tries left, key click and event code.
// An item is taken every cycle: the mode transition is one pass of logic into
// the state and result registers, and a two-deep output buffer keeps accepting
// while one result waits. in_ready_o drops only when both output slots are full.
// Configuration writes take effect at the next edge; write only while idle.
module keypad_pin_lock_controller (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [kplc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [kplc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire kplc_pkg::in_t                       in_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output kplc_pkg::out_t                           out_data_o
);

  logic [15:0] master_code_q, idle_sleep_q, entry_tmo_q, unlock_hold_q, lockout_hold_q;
  logic [3:0]  wrong_limit_q;

  kplc_pkg::mode_e                     mode_q, mode_d;
  logic [kplc_pkg::CNT_W-1:0]          cnt_q, cnt_d;
  logic                                mis_q, mis_d;
  logic [3:0]                          wrong_q, wrong_d;
  logic [4:0]                          prev_q, prev_d;
  logic [kplc_pkg::ELAPSED_W-1:0]      elapsed_q, elapsed_d;
  logic [kplc_pkg::BLINK_W-1:0]        blink_q, blink_d;
  logic                                armed_q, armed_d;

  logic           accept;
  logic [4:0]     pos;
  logic [3:0]     code;
  logic           dig_go;
  kplc_pkg::event_e ev;
  logic           click, red, green;
  kplc_pkg::out_t res;

  assign accept = in_valid_i && in_ready_o;
  assign pos    = (in_data_i.key_position > kplc_pkg::NO_KEY) ? kplc_pkg::NO_KEY
                                                              : in_data_i.key_position;
  assign code   = kplc_pkg::pad_code(pos[3:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      master_code_q  <= 16'd4660;
      wrong_limit_q  <= 4'd3;
      idle_sleep_q   <= 16'd10000;
      entry_tmo_q    <= 16'd7000;
      unlock_hold_q  <= 16'd5000;
      lockout_hold_q <= 16'd10000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        kplc_pkg::REG_MASTER_CODE:  master_code_q  <= cfg_data_i;
        kplc_pkg::REG_WRONG_LIMIT:  wrong_limit_q  <= cfg_data_i[3:0];
        kplc_pkg::REG_IDLE_SLEEP:   idle_sleep_q   <= cfg_data_i;
        kplc_pkg::REG_ENTRY_TMO:    entry_tmo_q    <= cfg_data_i;
        kplc_pkg::REG_UNLOCK_HOLD:  unlock_hold_q  <= cfg_data_i;
        kplc_pkg::REG_LOCKOUT_HOLD: lockout_hold_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    mode_d    = mode_q;
    cnt_d     = cnt_q;
    mis_d     = mis_q;
    wrong_d   = wrong_q;
    prev_d    = prev_q;
    elapsed_d = elapsed_q;
    blink_d   = blink_q;
    armed_d   = armed_q;
    ev        = kplc_pkg::EV_NONE;
    click     = 1'b0;
    dig_go    = 1'b0;

    case (in_data_i.action)
      kplc_pkg::ACT_TICK: begin
        if (elapsed_q != kplc_pkg::ELAPSED_MAX) begin
          elapsed_d = elapsed_q + 1'b1;
        end
        blink_d = (blink_q == kplc_pkg::BLINK_LAST) ? '0 : blink_q + 1'b1;
        case (mode_q)
          kplc_pkg::MODE_LOCKED: begin
            if (armed_q && elapsed_d > {1'b0, idle_sleep_q}) begin
              mode_d = kplc_pkg::MODE_SLEEP;
              ev     = kplc_pkg::EV_SLEPT;
            end
          end
          kplc_pkg::MODE_ENTERING: begin
            if (elapsed_d > {1'b0, entry_tmo_q}) begin
              cnt_d  = '0;
              mis_d  = 1'b0;
              mode_d = kplc_pkg::MODE_LOCKED;
              ev     = kplc_pkg::EV_ABORTED;
            end
          end
          kplc_pkg::MODE_UNLOCKED: begin
            if (elapsed_d > {1'b0, unlock_hold_q}) begin
              mode_d = kplc_pkg::MODE_LOCKED;
            end
          end
          kplc_pkg::MODE_LOCKOUT: begin
            if (elapsed_d > {1'b0, lockout_hold_q}) begin
              wrong_d = '0;
              mode_d  = kplc_pkg::MODE_LOCKED;
            end
          end
          default: ;
        endcase
      end
      kplc_pkg::ACT_WAKE: begin
        if (mode_q == kplc_pkg::MODE_SLEEP) begin
          mode_d    = kplc_pkg::MODE_LOCKED;
          elapsed_d = '0;
          armed_d   = 1'b1;
          ev        = kplc_pkg::EV_WOKE;
        end
      end
      kplc_pkg::ACT_KEY: begin
        if (mode_q != kplc_pkg::MODE_SLEEP) begin
          prev_d = pos;
          click  = (pos != kplc_pkg::NO_KEY);
          if (pos != prev_q && pos != kplc_pkg::NO_KEY) begin
            if (mode_q == kplc_pkg::MODE_LOCKED) begin
              if (code <= 4'd9) begin
                cnt_d     = '0;
                mis_d     = 1'b0;
                elapsed_d = '0;
                armed_d   = 1'b1;
                mode_d    = kplc_pkg::MODE_ENTERING;
                dig_go    = 1'b1;
              end else if (code == kplc_pkg::CODE_STAR) begin
                elapsed_d = '0;
                armed_d   = 1'b1;
              end
            end else if (mode_q == kplc_pkg::MODE_ENTERING) begin
              elapsed_d = '0;
              if (code == kplc_pkg::CODE_STAR) begin
                cnt_d  = '0;
                mis_d  = 1'b0;
                mode_d = kplc_pkg::MODE_LOCKED;
                ev     = kplc_pkg::EV_ABORTED;
              end else if (code <= 4'd9) begin
                dig_go = 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase

    if (dig_go && cnt_d < kplc_pkg::CNT_W'(kplc_pkg::PIN_LENGTH)) begin
      if (code != kplc_pkg::pin_digit(master_code_q, cnt_d)) begin
        mis_d = 1'b1;
      end
      cnt_d = cnt_d + 1'b1;
      if (cnt_d == kplc_pkg::CNT_W'(kplc_pkg::PIN_LENGTH)) begin
        if (!mis_d) begin
          wrong_d   = '0;
          elapsed_d = '0;
          mode_d    = kplc_pkg::MODE_UNLOCKED;
          ev        = kplc_pkg::EV_GRANTED;
        end else begin
          if (wrong_d != 4'd15) begin
            wrong_d = wrong_d + 1'b1;
          end
          if (wrong_d >= wrong_limit_q) begin
            elapsed_d = '0;
            mode_d    = kplc_pkg::MODE_LOCKOUT;
            ev        = kplc_pkg::EV_LOCKOUT;
          end else begin
            mode_d = kplc_pkg::MODE_LOCKED;
            ev     = kplc_pkg::EV_WRONG;
          end
        end
        cnt_d = '0;
        mis_d = 1'b0;
      end
    end

    red   = 1'b0;
    green = 1'b0;
    case (mode_d)
      kplc_pkg::MODE_LOCKED:   red = 1'b1;
      kplc_pkg::MODE_ENTERING: red = (blink_d < 9'd150);
      kplc_pkg::MODE_UNLOCKED: green = 1'b1;
      kplc_pkg::MODE_LOCKOUT:  red = (blink_d < 9'd50)
                                  || (blink_d >= 9'd100 && blink_d < 9'd150)
                                  || (blink_d >= 9'd200 && blink_d < 9'd250);
      default: ;
    endcase

    res.mode           = mode_d;
    res.red_led        = red;
    res.green_led      = green;
    res.digits_entered = 3'(cnt_d);
    res.tries_left     = (wrong_limit_q > wrong_d) ? (wrong_limit_q - wrong_d) : 4'd0;
    res.key_click      = click;
    res.event_res      = ev;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= kplc_pkg::MODE_SLEEP;
      cnt_q     <= '0;
      mis_q     <= 1'b0;
      wrong_q   <= '0;
      prev_q    <= kplc_pkg::NO_KEY;
      elapsed_q <= '0;
      blink_q   <= '0;
      armed_q   <= 1'b0;
    end else if (accept) begin
      mode_q    <= mode_d;
      cnt_q     <= cnt_d;
      mis_q     <= mis_d;
      wrong_q   <= wrong_d;
      prev_q    <= prev_d;
      elapsed_q <= elapsed_d;
      blink_q   <= blink_d;
      armed_q   <= armed_d;
    end
  end

  kplc_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (res),
    .space_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

FILE: design/kplc_checker.sv
`default_nettype none
module kplc_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_ready_o,
  input wire logic           out_valid_o,
  input wire logic           out_ready_i,
  input wire kplc_pkg::out_t out_data_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // input side stalls only behind a full, stalled output
  a_ready_only_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

  a_green_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.green_led |->
      out_data_o.mode == kplc_pkg::MODE_UNLOCKED && !out_data_o.red_led)
    else $error("green lamp outside unlocked mode");

  a_woke_locked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.event_res == kplc_pkg::EV_WOKE |->
      out_data_o.mode == kplc_pkg::MODE_LOCKED && !out_data_o.key_click)
    else $error("wake beat without locked mode");

  a_granted_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.event_res == kplc_pkg::EV_GRANTED |->
      out_data_o.mode == kplc_pkg::MODE_UNLOCKED && out_data_o.digits_entered == 3'd0)
    else $error("grant beat without unlock");

endmodule

bind keypad_pin_lock_controller kplc_checker u_kplc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire

FILE: bench/tb.sv
module tb;
  import kplc_pkg::*;

  localparam int ITEMS    = 1950;
  localparam int WATCHDOG = 1000;
  localparam logic [4:0] KEY_STAR = 5'd12;
  localparam logic [4:0] KEY_HASH = 5'd14;

  class lock_scoreboard;
    logic [15:0] pin_code;
    logic [3:0]  wrong_limit;
    logic [15:0] idle_sleep_ms, entry_tmo_ms, unlock_hold_ms, lockout_hold_ms;
    mode_e       lmode;
    logic [2:0]  digits;
    bit          mismatch;
    logic [3:0]  wrongs;
    logic [4:0]  prior_key;
    logic [16:0] elapsed;
    logic [8:0]  blink;
    bit          armed;
    logic [3:0]  pad_digit [16];
    out_t        expected [$];
    int          fails;
    int          results_seen;

    function new();
      pin_code = 16'h1234;
      wrong_limit = 4'd3;
      idle_sleep_ms = 16'd10000;
      entry_tmo_ms = 16'd7000;
      unlock_hold_ms = 16'd5000;
      lockout_hold_ms = 16'd10000;
      lmode = MODE_SLEEP;
      digits = '0;
      mismatch = 1'b0;
      wrongs = '0;
      prior_key = NO_KEY;
      elapsed = '0;
      blink = '0;
      armed = 1'b0;
      fails = 0;
      results_seen = 0;
      pad_digit = '{4'd1, 4'd2, 4'd3, CODE_LETTER, 4'd4, 4'd5, 4'd6, CODE_LETTER,
                    4'd7, 4'd8, 4'd9, CODE_LETTER, CODE_STAR, 4'd0, CODE_HASH, CODE_LETTER};
    endfunction

    function void set_reg(cfg_reg_e idx, logic [15:0] v);
      case (idx)
        REG_MASTER_CODE:  pin_code = v;
        REG_WRONG_LIMIT:  wrong_limit = v[3:0];
        REG_IDLE_SLEEP:   idle_sleep_ms = v;
        REG_ENTRY_TMO:    entry_tmo_ms = v;
        REG_UNLOCK_HOLD:  unlock_hold_ms = v;
        REG_LOCKOUT_HOLD: lockout_hold_ms = v;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected.size();
    endfunction

    function event_e take_digit(logic [3:0] dg);
      int sh;
      logic [3:0] want;
      if (digits >= PIN_LENGTH) return EV_NONE;
      sh = 4 * (int'(PIN_LENGTH) - 1 - int'(digits));
      want = (sh > 12) ? 4'd0 : 4'(pin_code >> sh);
      if (dg != want) mismatch = 1'b1;
      digits++;
      if (digits < PIN_LENGTH) return EV_NONE;
      digits = '0;
      if (!mismatch) begin
        wrongs = '0;
        elapsed = '0;
        lmode = MODE_UNLOCKED;
        return EV_GRANTED;
      end
      mismatch = 1'b0;
      if (wrongs != 4'hF) wrongs++;
      if (wrongs >= wrong_limit) begin
        elapsed = '0;
        lmode = MODE_LOCKOUT;
        return EV_LOCKOUT;
      end
      lmode = MODE_LOCKED;
      return EV_WRONG;
    endfunction

    function void note_input(in_t d);
      logic [4:0] pos;
      logic [3:0] code;
      event_e ev;
      bit click;
      bit fresh;
      out_t r;
      pos = (d.key_position > NO_KEY) ? NO_KEY : d.key_position;
      ev = EV_NONE;
      click = 1'b0;
      case (action_e'(d.action))
        ACT_TICK: begin
          if (elapsed != ELAPSED_MAX) elapsed++;
          blink = 9'((int'(blink) + 1) % 300);
          case (lmode)
            MODE_LOCKED: if (armed && elapsed > idle_sleep_ms) begin
              lmode = MODE_SLEEP;
              ev = EV_SLEPT;
            end
            MODE_ENTERING: if (elapsed > entry_tmo_ms) begin
              digits = '0;
              mismatch = 1'b0;
              lmode = MODE_LOCKED;
              ev = EV_ABORTED;
            end
            MODE_UNLOCKED: if (elapsed > unlock_hold_ms) lmode = MODE_LOCKED;
            MODE_LOCKOUT: if (elapsed > lockout_hold_ms) begin
              wrongs = '0;
              lmode = MODE_LOCKED;
            end
            default: ;
          endcase
        end
        ACT_WAKE: if (lmode == MODE_SLEEP) begin
          lmode = MODE_LOCKED;
          elapsed = '0;
          armed = 1'b1;
          ev = EV_WOKE;
        end
        ACT_KEY: if (lmode != MODE_SLEEP) begin
          fresh = (pos != prior_key);
          prior_key = pos;
          click = (pos != NO_KEY);
          if (fresh && pos != NO_KEY) begin
            code = pad_digit[pos[3:0]];
            if (lmode == MODE_LOCKED) begin
              if (code <= 4'd9) begin
                digits = '0;
                mismatch = 1'b0;
                elapsed = '0;
                armed = 1'b1;
                lmode = MODE_ENTERING;
                ev = take_digit(code);
              end else if (code == CODE_STAR) begin
                elapsed = '0;
                armed = 1'b1;
              end
            end else if (lmode == MODE_ENTERING) begin
              elapsed = '0;
              if (code == CODE_STAR) begin
                digits = '0;
                mismatch = 1'b0;
                lmode = MODE_LOCKED;
                ev = EV_ABORTED;
              end else if (code <= 4'd9) begin
                ev = take_digit(code);
              end
            end
          end
        end
        default: ;
      endcase
      r = '0;
      r.mode = lmode;
      case (lmode)
        MODE_LOCKED:   r.red_led = 1'b1;
        MODE_ENTERING: r.red_led = (blink < 150);
        MODE_UNLOCKED: r.green_led = 1'b1;
        MODE_LOCKOUT:  r.red_led = ((blink % 100) < 50);
        default: ;
      endcase
      r.digits_entered = digits;
      r.tries_left = (wrong_limit > wrongs) ? wrong_limit - wrongs : 4'd0;
      r.key_click = click;
      r.event_res = ev;
      expected.push_back(r);
    endfunction

    task report(string msg);
      fails++;
      $display("mismatch: %s", msg);
    endtask

    task compare_field(string field, logic [3:0] got, logic [3:0] want);
      if (got !== want)
        report($sformatf("beat %0d %s: got %0h, expected %0h", results_seen, field, got, want));
    endtask

    task check_result(out_t got);
      out_t want;
      results_seen++;
      if (expected.size() == 0) begin
        report($sformatf("beat %0d arrived with nothing outstanding (%h)", results_seen, got));
        return;
      end
      want = expected.pop_front();
      compare_field("mode", got.mode, want.mode);
      compare_field("red_led", got.red_led, want.red_led);
      compare_field("green_led", got.green_led, want.green_led);
      compare_field("digits_entered", got.digits_entered, want.digits_entered);
      compare_field("tries_left", got.tries_left, want.tries_left);
      compare_field("key_click", got.key_click, want.key_click);
      compare_field("event_res", got.event_res, want.event_res);
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = REG_MASTER_CODE;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  in_t                   in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_t                  out_data_o;

  lock_scoreboard sb;
  bit steady = 1'b0;
  int beats_in = 0;
  int quiet = 0;
  logic [4:0] digit_key [10] = '{5'd13, 5'd0, 5'd1, 5'd2, 5'd4, 5'd5, 5'd6, 5'd8, 5'd9, 5'd10};

  keypad_pin_lock_controller uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int gap_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        sb.note_input(in_data_i);
        beats_in++;
      end
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int stall;
    stall = 0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready_i = 1'b0;
        stall--;
      end else begin
        out_ready_i = 1'b1;
        stall = gap_len();
      end
    end
  end

  task automatic send(action_e act, logic [4:0] pos);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i = '{action: act, key_position: pos};
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic press(logic [4:0] pos);
    send(ACT_KEY, pos);
  endtask

  task automatic ticks(int n);
    repeat (n) send(ACT_TICK, 5'($urandom));
  endtask

  task automatic noise(int n);
    repeat (n) send(action_e'($urandom_range(0, 3)), 5'($urandom));
  endtask

  task automatic hold_off();
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [15:0] v);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = v;
    sb.set_reg(idx, v);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic configure(logic [15:0] code, logic [15:0] lim, logic [15:0] idle,
                           logic [15:0] entry, logic [15:0] hold, logic [15:0] lockout);
    hold_off();
    write_reg(REG_MASTER_CODE, code);
    write_reg(REG_WRONG_LIMIT, lim);
    write_reg(REG_IDLE_SLEEP, idle);
    write_reg(REG_ENTRY_TMO, entry);
    write_reg(REG_UNLOCK_HOLD, hold);
    write_reg(REG_LOCKOUT_HOLD, lockout);
  endtask

  function automatic logic [15:0] timeout_val();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 16'($urandom_range(1, 25));
    if (r < 85) return 16'($urandom_range(26, 400));
    if (r < 93) return 16'd1;
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] bcd_code();
    if ($urandom_range(0, 5) == 0) return 16'($urandom);
    return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
            4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
  endfunction

  // short limits expire for real, long ones just see a few ticks
  task automatic run_out(logic [15:0] lim);
    if (lim <= 60) ticks(int'(lim) + $urandom_range(1, 3));
    else ticks($urandom_range(1, 30));
  endtask

  task automatic enter_pin(bit right, int upto);
    int bad;
    int i;
    logic [3:0] dg;
    logic [3:0] alt;
    bad = right ? -1 : $urandom_range(0, PIN_LENGTH - 1);
    for (i = 0; i < upto; i++) begin
      dg = 4'(sb.pin_code >> (4 * (PIN_LENGTH - 1 - i)));
      if (i == bad || dg > 4'd9) begin
        do alt = 4'($urandom_range(0, 9)); while (alt == dg);
        dg = alt;
      end
      press(digit_key[dg]);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: press(NO_KEY);
        6: press(($urandom_range(0, 4) == 0) ? KEY_HASH : 5'(4 * $urandom_range(0, 3) + 3));
        7: ticks($urandom_range(1, 3));
        8: begin
          press(NO_KEY);
          press(NO_KEY);
        end
        default: ;
      endcase
    end
    press(NO_KEY);
  endtask

  task automatic session();
    int r;
    steady = ($urandom_range(0, 5) == 0);
    send(ACT_WAKE, 5'($urandom));
    repeat ($urandom_range(2, 8)) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        enter_pin(1'b1, PIN_LENGTH);
        if ($urandom_range(0, 1)) run_out(sb.unlock_hold_ms);
      end else if (r < 65) begin
        enter_pin(1'b0, PIN_LENGTH);
        if (sb.lmode == MODE_LOCKOUT) run_out(sb.lockout_hold_ms);
      end else if (r < 75) begin
        enter_pin(1'b0, $urandom_range(1, PIN_LENGTH - 1));
        press(KEY_STAR);
        press(NO_KEY);
      end else if (r < 83) begin
        enter_pin(1'b0, $urandom_range(1, PIN_LENGTH - 1));
        run_out(sb.entry_tmo_ms);
      end else if (r < 88) begin
        press(KEY_STAR);
        press(NO_KEY);
      end else if (r < 97) begin
        noise($urandom_range(1, 6));
      end else begin
        hold_off();
      end
    end
    if ($urandom_range(0, 2) == 0) run_out(sb.idle_sleep_ms);
  endtask

  initial begin
    int phase;
    int quota;
    sb = new();
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // sleep, wake, pad corners, abort, then the reset PIN 1-2-3-4
    press(5'd5);
    send(ACT_TICK, 5'd31);
    send(ACT_NOP, 5'd31);
    send(ACT_WAKE, 5'd0);
    send(ACT_WAKE, 5'd16);
    press(5'd31);
    press(KEY_HASH);
    press(5'd3);
    press(KEY_STAR);
    press(NO_KEY);
    press(5'd0);
    press(5'd1);
    press(5'd1);
    press(KEY_STAR);
    press(5'd0);
    press(5'd1);
    press(5'd2);
    press(5'd4);
    press(5'd5);
    press(NO_KEY);
    hold_off();

    phase = 0;
    while (beats_in < ITEMS) begin
      case (phase)
        0: configure(16'h1234, 16'd3, 16'd20, 16'd12, 16'd8, 16'd15);
        1: configure(16'h0000, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
        2: configure(16'hFFFF, 16'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1);
        3: configure(bcd_code(), 16'hABC0, 16'd5, 16'd6, 16'd4, 16'd3);
        4: configure(16'h9999, 16'hFFFF, 16'd9, 16'd7, 16'd5, 16'hFFFF);
        default: configure(bcd_code(),
                           {12'($urandom), 4'($urandom_range(0, 15))},
                           timeout_val(), timeout_val(), timeout_val(), timeout_val());
      endcase
      quota = beats_in + 200;
      while (beats_in < quota && beats_in < ITEMS) session();
      phase++;
    end

    hold_off();
    steady = 1'b0;
    repeat (20) @(negedge clk_i);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.fails == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
